[rtl/m3it_pkg.sv]
`timescale 1ns / 1ps

package m3it_pkg;

  // Element count and float32 layout.
  localparam int EL_N = 9;
  localparam int FP_W = 32;
  localparam int DATA_W = EL_N * FP_W;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // Pipeline depths, in cycles, of the parts between stages of the top level.
  localparam int A_DLY = 6;   // inputs kept until the determinant products start
  localparam int P_DLY = 3;   // third determinant product waits for the first add
  localparam int C_DLY = 18;  // cofactors wait for the reciprocal
  localparam int Z_DLY = 12;  // zero-determinant flag waits for the final products
  localparam int LAT = 27;    // total latency from accepted word to result word

  // Reciprocal divider: 28 quotient bits, 4 bits per stage.
  localparam int DIV_STG = 7;
  localparam int DIV_BITS = 4;

  // Operand indexes of each cofactor x*y - z*w, element index = 3*col + row.
  localparam logic [3:0] COF_IDX [0:EL_N-1][0:3] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd6, 4'd5, 4'd3, 4'd8},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd7, 4'd2, 4'd1, 4'd8},
    '{4'd0, 4'd8, 4'd6, 4'd2},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  // Leading zero count of a 27-bit word (27 when the word is zero).
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack. The mantissa has its leading one at bit 26
  // and e is the biased exponent of that leading one; st collects lower bits.
  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
                                           input logic [26:0] m, input logic st);
    logic [11:0] sh;
    logic [53:0] wide;
    logic [26:0] ms;
    logic stk;
    logic [7:0] ef;
    logic up;
    sh = 12'd0;
    wide = '0;
    ms = m;
    stk = st;
    ef = 8'd0;
    if (e >= 12'sd255) begin
      return {sgn, 8'hFF, 23'd0};
    end
    if (e <= 12'sd0) begin
      // Subnormal result: denormalize before rounding.
      sh = 12'd1 - e;
      if (sh > 12'd27) begin
        ms = '0;
        stk = st | (|m);
      end else begin
        wide = {m, 27'd0} >> sh[4:0];
        ms = wide[53:27];
        stk = st | (|wide[26:0]);
      end
      ef = 8'd0;
    end else begin
      ef = e[7:0];
    end
    up = ms[2] & (ms[1] | ms[0] | stk | ms[3]);
    // A carry out of the fraction moves into the exponent field.
    return {sgn, ef, ms[25:3]} + {31'd0, up};
  endfunction

endpackage

[rtl/m3it_fmul.sv]
`timescale 1ns / 1ps

module m3it_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import m3it_pkg::*;

  // Unpack and normalize both operands.
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [23:0] ma_raw, mb_raw;
  logic [4:0]  lza, lzb;
  logic signed [11:0] ea_n, eb_n;

  assign a_nan  = (&a[30:23]) & (|a[22:0]);
  assign a_inf  = (&a[30:23]) & ~(|a[22:0]);
  assign a_zero = ~(|a[30:0]);
  assign b_nan  = (&b[30:23]) & (|b[22:0]);
  assign b_inf  = (&b[30:23]) & ~(|b[22:0]);
  assign b_zero = ~(|b[30:0]);
  assign ma_raw = {|a[30:23], a[22:0]};
  assign mb_raw = {|b[30:23], b[22:0]};
  assign lza    = lzc27({ma_raw, 3'b000});
  assign lzb    = lzc27({mb_raw, 3'b000});
  assign ea_n   = $signed({4'd0, (|a[30:23]) ? a[30:23] : 8'd1}) - $signed({7'd0, lza});
  assign eb_n   = $signed({4'd0, (|b[30:23]) ? b[30:23] : 8'd1}) - $signed({7'd0, lzb});

  logic        s1_sgn, s1_nan, s1_inf, s1_zero;
  logic [23:0] s1_ma, s1_mb;
  logic signed [11:0] s1_e;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sgn  <= a[31] ^ b[31];
      s1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      s1_inf  <= a_inf | b_inf;
      s1_zero <= a_zero | b_zero;
      s1_ma   <= ma_raw << lza;
      s1_mb   <= mb_raw << lzb;
      s1_e    <= ea_n + eb_n - 12'sd127;
    end
  end

  // Mantissa product.
  logic        s2_sgn, s2_nan, s2_inf, s2_zero;
  logic [47:0] s2_p;
  logic signed [11:0] s2_e;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sgn  <= s1_sgn;
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;
      s2_zero <= s1_zero;
      s2_p    <= s1_ma * s1_mb;
      s2_e    <= s1_e;
    end
  end

  // Normalize by at most one place, then round and handle special operands.
  logic [26:0] m;
  logic        st;
  logic signed [11:0] e;
  logic [31:0] y_next;

  always_comb begin
    if (s2_p[47]) begin
      m = s2_p[47:21];
      st = |s2_p[20:0];
      e = s2_e + 12'sd1;
    end else begin
      m = s2_p[46:20];
      st = |s2_p[19:0];
      e = s2_e;
    end
    if (s2_nan) y_next = QNAN;
    else if (s2_inf) y_next = {s2_sgn, 8'hFF, 23'd0};
    else if (s2_zero) y_next = {s2_sgn, 31'd0};
    else y_next = fp_round(s2_sgn, e, m, st);
  end

  always_ff @(posedge clk) begin
    if (en) y <= y_next;
  end

endmodule

[rtl/m3it_fadd.sv]
`timescale 1ns / 1ps

module m3it_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] y
);
  import m3it_pkg::*;

  // Order the operands by magnitude and align the smaller one.
  logic [31:0] bb, big, sml;
  logic        swap, a_nan, a_inf, b_nan, b_inf;
  logic [7:0]  el, es, d;
  logic [23:0] ml, msm;
  logic [53:0] wide;
  logic [26:0] al;
  logic        stk;

  always_comb begin
    bb    = {b[31] ^ sub, b[30:0]};
    a_nan = (&a[30:23]) & (|a[22:0]);
    a_inf = (&a[30:23]) & ~(|a[22:0]);
    b_nan = (&bb[30:23]) & (|bb[22:0]);
    b_inf = (&bb[30:23]) & ~(|bb[22:0]);
    swap  = bb[30:0] > a[30:0];
    big   = swap ? bb : a;
    sml   = swap ? a : bb;
    el    = (|big[30:23]) ? big[30:23] : 8'd1;
    es    = (|sml[30:23]) ? sml[30:23] : 8'd1;
    ml    = {|big[30:23], big[22:0]};
    msm   = {|sml[30:23], sml[22:0]};
    d     = el - es;
    wide  = '0;
    if (d >= 8'd27) begin
      al  = '0;
      stk = |msm;
    end else begin
      wide = {msm, 3'b000, 27'd0} >> d[4:0];
      al   = wide[53:27];
      stk  = |wide[26:0];
    end
  end

  logic        s1_sgn, s1_op, s1_nan, s1_inf, s1_isgn;
  logic [26:0] s1_ml, s1_ms;
  logic [7:0]  s1_e;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sgn  <= big[31];
      s1_op   <= a[31] ^ bb[31];
      s1_nan  <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ bb[31]));
      s1_inf  <= a_inf | b_inf;
      s1_isgn <= a_inf ? a[31] : bb[31];
      s1_ml   <= {ml, 3'b000};
      s1_ms   <= {al[26:1], al[0] | stk};
      s1_e    <= el;
    end
  end

  // Add or subtract, then normalize.
  logic [27:0] sum;
  logic [4:0]  lz;
  logic [26:0] nm;
  logic        nst;
  logic signed [11:0] ne;

  always_comb begin
    sum = s1_op ? ({1'b0, s1_ml} - {1'b0, s1_ms}) : ({1'b0, s1_ml} + {1'b0, s1_ms});
    lz  = lzc27(sum[26:0]);
    if (sum[27]) begin
      nm  = sum[27:1];
      nst = sum[0];
      ne  = $signed({4'd0, s1_e}) + 12'sd1;
    end else begin
      nm  = sum[26:0] << lz;
      nst = 1'b0;
      ne  = $signed({4'd0, s1_e}) - $signed({7'd0, lz});
    end
  end

  logic        s2_sgn, s2_nan, s2_inf, s2_isgn, s2_zero, s2_st;
  logic [26:0] s2_m;
  logic signed [11:0] s2_e;

  always_ff @(posedge clk) begin
    if (en) begin
      // An exact zero sum is +0 unless both operands were negative zeros.
      s2_sgn  <= (sum == 28'd0) ? (s1_sgn & ~s1_op) : s1_sgn;
      s2_zero <= (sum == 28'd0);
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;
      s2_isgn <= s1_isgn;
      s2_m    <= nm;
      s2_st   <= nst;
      s2_e    <= ne;
    end
  end

  // Round and handle special operands.
  logic [31:0] y_next;

  always_comb begin
    if (s2_nan) y_next = QNAN;
    else if (s2_inf) y_next = {s2_isgn, 8'hFF, 23'd0};
    else if (s2_zero) y_next = {s2_sgn, 31'd0};
    else y_next = fp_round(s2_sgn, s2_e, s2_m, s2_st);
  end

  always_ff @(posedge clk) begin
    if (en) y <= y_next;
  end

endmodule

[rtl/matrix3_inverse_transpose_top.sv]
`timescale 1ns / 1ps

// Channel  Dir  tdata                       tuser
// s_axis   in   m00 m10 m20 m01 .. m22      -
// m_axis   out  r00 r10 r20 r01 .. r22      ok
//
// A new matrix word is taken in every cycle while the pipeline is not held.
// Each word passes through the cofactor products, cofactor subtract,
// determinant products and two determinant adds, a reciprocal (unpack,
// seven divider stages of 4 quotient bits, round) and the final scaling
// products.
// Reset (rst, synchronous) clears only the valid bits of the pipeline.
// When m_tready is low with a result waiting, the whole pipeline holds.

module matrix3_inverse_transpose_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [m3it_pkg::DATA_W-1:0]   s_tdata,   // m00, m10, m20, m01, m11, m21, m02, m12, m22
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [m3it_pkg::DATA_W-1:0]   m_tdata,   // r00, r10, r20, r01, r11, r21, r02, r12, r22
  output logic                          m_tuser    // ok
);
  import m3it_pkg::*;

  // Global pipeline advance.
  logic           en;
  logic [LAT-1:0] vld;

  assign en       = ~vld[LAT-1] | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_tvalid};
  end

  // Input elements.
  logic [31:0] a_in [0:EL_N-1];
  logic [31:0] pa [0:EL_N-1];
  logic [31:0] pb [0:EL_N-1];
  logic [31:0] cof [0:EL_N-1];

  // Cofactors: two products and a subtract each.
  for (genvar gi = 0; gi < EL_N; gi++) begin : g_cof
    assign a_in[gi] = s_tdata[FP_W*gi +: FP_W];

    m3it_fmul u_mx (
      .clk(clk), .en(en), .a(a_in[COF_IDX[gi][0]]), .b(a_in[COF_IDX[gi][1]]), .y(pa[gi])
    );
    m3it_fmul u_mz (
      .clk(clk), .en(en), .a(a_in[COF_IDX[gi][2]]), .b(a_in[COF_IDX[gi][3]]), .y(pb[gi])
    );
    m3it_fadd u_sub (
      .clk(clk), .en(en), .a(pa[gi]), .b(pb[gi]), .sub(1'b1), .y(cof[gi])
    );
  end

  // Keep a0, a3 and a6 until the cofactors are ready.
  logic [31:0] ad [0:A_DLY-1][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      ad[0][0] <= a_in[0];
      ad[0][1] <= a_in[3];
      ad[0][2] <= a_in[6];
      for (int k = 1; k < A_DLY; k++) ad[k] <= ad[k-1];
    end
  end

  // Determinant: (a6*c6 + a3*c3) + a0*c0.
  logic [31:0] p6, p3, p0, s63, det;
  logic [31:0] pd [0:P_DLY-1];

  m3it_fmul u_dm6 (.clk(clk), .en(en), .a(ad[A_DLY-1][2]), .b(cof[6]), .y(p6));
  m3it_fmul u_dm3 (.clk(clk), .en(en), .a(ad[A_DLY-1][1]), .b(cof[3]), .y(p3));
  m3it_fmul u_dm0 (.clk(clk), .en(en), .a(ad[A_DLY-1][0]), .b(cof[0]), .y(p0));

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0] <= p0;
      for (int k = 1; k < P_DLY; k++) pd[k] <= pd[k-1];
    end
  end

  m3it_fadd u_da1 (.clk(clk), .en(en), .a(p6), .b(p3), .sub(1'b0), .y(s63));
  m3it_fadd u_da2 (.clk(clk), .en(en), .a(s63), .b(pd[P_DLY-1]), .sub(1'b0), .y(det));

  // Reciprocal front end: unpack and normalize the determinant.
  logic        dt_nan, dt_inf;
  logic [23:0] dt_m;
  logic [4:0]  dt_lz;
  logic signed [11:0] dt_e;

  assign dt_nan = (&det[30:23]) & (|det[22:0]);
  assign dt_inf = (&det[30:23]) & ~(|det[22:0]);
  assign dt_m   = {|det[30:23], det[22:0]};
  assign dt_lz  = lzc27({dt_m, 3'b000});
  assign dt_e   = $signed({4'd0, (|det[30:23]) ? det[30:23] : 8'd1}) - $signed({7'd0, dt_lz});

  // Restoring divider stages computing floor(2^50 / mantissa).
  logic [24:0] rq_r   [0:DIV_STG];
  logic [27:0] rq_q   [0:DIV_STG];
  logic [23:0] rq_md  [0:DIV_STG];
  logic signed [11:0] rq_e [0:DIV_STG];
  logic        rq_s   [0:DIV_STG];
  logic        rq_nan [0:DIV_STG];
  logic        rq_inf [0:DIV_STG];
  logic [24:0] nx_r   [1:DIV_STG];
  logic [27:0] nx_q   [1:DIV_STG];

  always_comb begin
    for (int k = 1; k <= DIV_STG; k++) begin
      nx_r[k] = rq_r[k-1];
      nx_q[k] = rq_q[k-1];
      for (int j = 0; j < DIV_BITS; j++) begin
        if (nx_r[k] >= {1'b0, rq_md[k-1]}) begin
          nx_r[k] = nx_r[k] - {1'b0, rq_md[k-1]};
          nx_q[k] = {nx_q[k][26:0], 1'b1};
        end else begin
          nx_q[k] = {nx_q[k][26:0], 1'b0};
        end
        nx_r[k] = {nx_r[k][23:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rq_r[0]   <= 25'h080_0000;
      rq_q[0]   <= '0;
      rq_md[0]  <= dt_m << dt_lz;
      rq_e[0]   <= dt_e;
      rq_s[0]   <= det[31];
      rq_nan[0] <= dt_nan;
      rq_inf[0] <= dt_inf;
      for (int k = 1; k <= DIV_STG; k++) begin
        rq_r[k]   <= nx_r[k];
        rq_q[k]   <= nx_q[k];
        rq_md[k]  <= rq_md[k-1];
        rq_e[k]   <= rq_e[k-1];
        rq_s[k]   <= rq_s[k-1];
        rq_nan[k] <= rq_nan[k-1];
        rq_inf[k] <= rq_inf[k-1];
      end
    end
  end

  // Round the reciprocal.
  logic [27:0] qf;
  logic [26:0] im;
  logic        ist;
  logic signed [11:0] ie;
  logic [31:0] inv, inv_next;

  always_comb begin
    qf  = rq_q[DIV_STG];
    ist = (|rq_r[DIV_STG]) | (qf[27] & qf[0]);
    if (qf[27]) begin
      im = qf[27:1];
      ie = 12'sd254 - rq_e[DIV_STG];
    end else begin
      im = qf[26:0];
      ie = 12'sd253 - rq_e[DIV_STG];
    end
    if (rq_nan[DIV_STG]) inv_next = QNAN;
    else if (rq_inf[DIV_STG]) inv_next = {rq_s[DIV_STG], 31'd0};
    else inv_next = fp_round(rq_s[DIV_STG], ie, im, ist);
  end

  always_ff @(posedge clk) begin
    if (en) inv <= inv_next;
  end

  // Cofactors wait for the reciprocal; the zero flag waits for the result.
  logic [31:0] cd [0:C_DLY-1][0:EL_N-1];
  logic        zd [0:Z_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      cd[0] <= cof;
      for (int k = 1; k < C_DLY; k++) cd[k] <= cd[k-1];
      zd[0] <= ~(|det[30:0]);
      for (int k = 1; k < Z_DLY; k++) zd[k] <= zd[k-1];
    end
  end

  // Scale each cofactor; a singular matrix gives an all-zero word.
  logic [31:0] fin [0:EL_N-1];

  for (genvar gi = 0; gi < EL_N; gi++) begin : g_out
    m3it_fmul u_sc (.clk(clk), .en(en), .a(cd[C_DLY-1][gi]), .b(inv), .y(fin[gi]));
    assign m_tdata[FP_W*gi +: FP_W] = zd[Z_DLY-1] ? '0 : fin[gi];
  end

  assign m_tuser = ~zd[Z_DLY-1];

endmodule
